// ===== rtl/core/lnes_pkg.sv =====
// shared types and constants of the looped note event scheduler
`default_nettype none
package lnes_pkg;

    localparam int BEAT_W   = 48;
    localparam int BPS_W    = 32;
    localparam int POS_W    = 24;
    localparam int PITCH_W  = 7;
    localparam int ALU_W    = 58;
    localparam int ACC_W    = 56;
    localparam int DIV_W    = 49;
    localparam int REM_W    = 33;
    localparam int EVC_W    = 6;
    localparam int CNT_W    = 6;

    localparam logic [EVC_W-1:0] MAX_EVENTS = 6'd48;
    localparam logic [CNT_W-1:0] DIV_LAST   = 6'd48;
    localparam logic [CNT_W-1:0] MUL_LAST   = 6'd23;
    localparam logic [BEAT_W-1:0] BEAT_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [BPS_W-1:0] BPS_RESET  = 32'd4294967;
    localparam logic [POS_W-1:0] LEN_RESET  = 24'd1;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_TICK = 3'd1;
    localparam logic [2:0] OP_PLAY = 3'd2;
    localparam logic [2:0] OP_STOP = 3'd3;
    localparam logic [2:0] OP_SEEK = 3'd4;

    localparam logic EV_ON  = 1'b0;
    localparam logic EV_OFF = 1'b1;

    localparam logic [1:0] CFG_LOOP_START = 2'd0;
    localparam logic [1:0] CFG_LOOP_END   = 2'd1;
    localparam logic [1:0] CFG_BPS        = 2'd2;
    localparam logic [1:0] CFG_LOOP_LEN   = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         entry_index;
        logic [BEAT_W-1:0]  entry_start_beat;
        logic [BEAT_W-1:0]  entry_length_beat;
        logic [PITCH_W-1:0] entry_pitch;
        logic               load_last;
        logic [BEAT_W-1:0]  seek_beat;
    } req_t;

    typedef struct packed {
        logic               event_kind;
        logic [PITCH_W-1:0] event_pitch;
        logic               event_last;
    } evt_t;

    typedef struct packed {
        logic [BEAT_W-1:0]  start;
        logic [BEAT_W-1:0]  length;
        logic [PITCH_W-1:0] pitch;
    } entry_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } alu_res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REL,
        ST_SEEK_SUB,
        ST_SEEK_ADD,
        ST_DIV,
        ST_CLAMP,
        ST_MUL,
        ST_SPAN_LO,
        ST_SPAN_HI,
        ST_E_ADDR,
        ST_E_NE,
        ST_E_ON,
        ST_E_OFF,
        ST_REM,
        ST_ADV,
        ST_PH,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/lnes_alu.sv =====
// shared adder and subtractor used by the seek, division, clamp, multiply, span, note-end and playhead steps
`default_nettype none
module lnes_alu
    import lnes_pkg::*;
(
    input  wire logic [ALU_W-1:0] a,
    input  wire logic [ALU_W-1:0] b,
    input  wire logic             sub,
    output alu_res_t              res
);

    logic [ALU_W:0] total;

    always_comb
    begin
        total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ALU_W{1'b0}}, sub};
        res.sum = total[ALU_W-1:0];
        res.carry = total[ALU_W];
    end

endmodule
`default_nettype wire

// ===== rtl/core/lnes_table.sv =====
// double-banked note table memory with registered read
`default_nettype none
module lnes_table
    import lnes_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/looped_note_event_scheduler.sv =====
// top level: transport, sequencer, sounding list and event output of the scheduler
// Load, play, stop and seek requests complete on acceptance and leave the sequencer idle. A
// tick runs a sequencer around one shared 58-bit adder. When stopped, it only releases the
// sounding notes; when running with a degenerate loop, it does nothing. Otherwise it runs, on
// a pending seek, a release pass, a subtract and an add, restoring division and a clamp;
// then a shift-add multiply, the span bounds, per active entry an address, note-end, note-on
// and note-off step plus, when its end falls in the span, a removal pass; a step closing the
// scan, an advance step, a release pass at the loop end, a multiply for the playhead and a
// closing step. Steps that emit an event wait while the event output is stalled.
`default_nettype none
module looped_note_event_scheduler
    import lnes_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int SOUNDING_SLOTS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req_data,
    output logic             evt_valid,
    input  wire logic        evt_stall,
    output evt_t             evt_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int DEPTH = 2 * TABLE_ENTRIES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TCW = $clog2(TABLE_ENTRIES + 1);
    localparam int SCW = $clog2(SOUNDING_SLOTS + 1);
    localparam int SIW = (SOUNDING_SLOTS > 1) ? $clog2(SOUNDING_SLOTS) : 1;

    logic [BEAT_W-1:0] loop_start_reg;
    logic [BEAT_W-1:0] loop_end_reg;
    logic [BPS_W-1:0]  bps_reg;
    logic [POS_W-1:0]  len_reg;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [REM_W-1:0] r_reg, r_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [ALU_W-1:0] lo_reg, lo_next;
    logic [ALU_W-1:0] hi_reg, hi_next;
    logic [DIV_W-1:0] ne_reg, ne_next;
    logic [TCW-1:0] idx_reg, idx_next;
    logic [SCW-1:0] si_reg, si_next;
    logic [SCW-1:0] sk_reg, sk_next;
    logic [TCW-1:0] bank_cnt_reg [2];
    logic [TCW-1:0] bank_cnt_next [2];
    logic active_bank_reg, active_bank_next;
    logic [PITCH_W-1:0] snd_reg [SOUNDING_SLOTS];
    logic [PITCH_W-1:0] snd_next [SOUNDING_SLOTS];
    logic [SCW-1:0] snd_cnt_reg, snd_cnt_next;
    logic [BEAT_W-1:0] playhead_reg, playhead_next;
    logic [BEAT_W-1:0] pending_reg, pending_next;
    logic seek_pending_reg, seek_pending_next;
    logic running_reg, running_next;
    logic hold_valid_reg, hold_valid_next;
    evt_t hold_reg, hold_next;
    logic [EVC_W-1:0] ev_cnt_reg, ev_cnt_next;
    logic evt_valid_reg, evt_valid_next;
    evt_t evt_reg, evt_next;

    logic [ALU_W-1:0] alu_a, alu_b;
    logic alu_sub;
    alu_res_t alu_y;

    logic tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr, tbl_rd_addr;
    entry_t tbl_wr_data, ent;

    logic accept, degenerate, rel_more, idx_more, on_hit, off_hit, wrap;
    logic ev_room, out_free, emit_ok, emit_req, emit_kind;
    logic [PITCH_W-1:0] emit_pitch;
    logic [POS_W-1:0] len_eff, lenm1;
    logic [POS_W:0] np;
    logic [4:0] mbit;
    logic [4:0] load_c;
    logic [REM_W-1:0] rs;
    logic [ALU_W-1:0] ne_ext;
    logic [BEAT_W-1:0] target;

    lnes_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_y)
    );

    lnes_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (ent)
    );

    assign pready = 1'b1;
    assign req_stall = (state_reg != ST_IDLE);
    assign accept = req_valid && (state_reg == ST_IDLE);
    assign evt_valid = evt_valid_reg;
    assign evt_data = evt_reg;

    assign degenerate = (loop_end_reg <= loop_start_reg) || (bps_reg == '0);
    assign rel_more = si_reg < snd_cnt_reg;
    assign idx_more = idx_reg < bank_cnt_reg[active_bank_reg];
    assign len_eff = (len_reg == '0) ? LEN_RESET : len_reg;
    assign lenm1 = len_eff - LEN_RESET;
    assign np = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1};
    assign wrap = np >= {1'b0, len_eff};
    assign ne_ext = ALU_W'(ne_reg);
    assign on_hit = (ALU_W'(ent.start) >= lo_reg) && (ALU_W'(ent.start) < hi_reg);
    assign off_hit = (ne_ext >= lo_reg) && (ne_ext < hi_reg);
    assign ev_room = ev_cnt_reg < MAX_EVENTS;
    assign out_free = !evt_valid_reg || !evt_stall;
    assign emit_ok = !ev_room || !hold_valid_reg || out_free;
    assign mbit = 5'(MUL_LAST) - cnt_reg[4:0];
    assign load_c = {1'b0, req_data.entry_index} + 5'd1;
    assign rs = {r_reg[REM_W-2:0], d_reg[DIV_W-1]};
    assign target = ((pending_reg < loop_start_reg) || (pending_reg >= loop_end_reg))
                    ? loop_start_reg : pending_reg;
    assign tbl_rd_addr = AW'(active_bank_reg ? TABLE_ENTRIES : 0) + AW'(idx_reg);

    always_comb
    begin
        prdata = '0;
        unique case (paddr[4:3])
            CFG_LOOP_START: prdata = 64'(loop_start_reg);
            CFG_LOOP_END:   prdata = 64'(loop_end_reg);
            CFG_BPS:        prdata = 64'(bps_reg);
            CFG_LOOP_LEN:   prdata = 64'(len_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_start_reg <= '0;
            loop_end_reg <= '0;
            bps_reg <= BPS_RESET;
            len_reg <= LEN_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:3])
                CFG_LOOP_START: loop_start_reg <= pwdata[BEAT_W-1:0];
                CFG_LOOP_END:   loop_end_reg <= pwdata[BEAT_W-1:0];
                CFG_BPS:        bps_reg <= pwdata[BPS_W-1:0];
                CFG_LOOP_LEN:   len_reg <= pwdata[POS_W-1:0];
            endcase
        end
    end

    // shared adder operand select
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_SEEK_SUB:
            begin
                alu_a = ALU_W'(target);
                alu_b = ALU_W'(loop_start_reg);
                alu_sub = 1'b1;
            end
            ST_SEEK_ADD:
            begin
                alu_a = ALU_W'(d_reg);
                alu_b = ALU_W'(bps_reg[BPS_W-1:1]);
            end
            ST_DIV:
            begin
                alu_a = ALU_W'(rs);
                alu_b = ALU_W'(bps_reg);
                alu_sub = 1'b1;
            end
            ST_CLAMP:
            begin
                alu_a = ALU_W'(lenm1);
                alu_b = ALU_W'(d_reg);
                alu_sub = 1'b1;
            end
            ST_MUL:
            begin
                alu_a = ALU_W'({acc_reg, 1'b0});
                alu_b = pos_reg[mbit] ? ALU_W'(bps_reg) : '0;
            end
            ST_SPAN_LO, ST_PH:
            begin
                alu_a = ALU_W'(loop_start_reg);
                alu_b = ALU_W'(acc_reg);
            end
            ST_SPAN_HI:
            begin
                alu_a = lo_reg;
                alu_b = ALU_W'(bps_reg);
            end
            ST_E_NE:
            begin
                alu_a = ALU_W'(ent.start);
                alu_b = ALU_W'(ent.length);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_data.op == OP_TICK))
                begin
                    if (!running_reg)
                    begin
                        state_next = ST_REL;
                    end
                    else if (degenerate)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (seek_pending_reg)
                    begin
                        state_next = ST_REL;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_REL:
            begin
                if (!rel_more)
                begin
                    state_next = ret_reg;
                end
            end
            ST_SEEK_SUB: state_next = ST_SEEK_ADD;
            ST_SEEK_ADD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_MUL;
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = phase_reg ? ST_PH : ST_SPAN_LO;
                end
            end
            ST_SPAN_LO: state_next = ST_SPAN_HI;
            ST_SPAN_HI: state_next = ST_E_ADDR;
            ST_E_ADDR: state_next = idx_more ? ST_E_NE : ST_ADV;
            ST_E_NE: state_next = ST_E_ON;
            ST_E_ON:
            begin
                if (!on_hit || emit_ok)
                begin
                    state_next = ST_E_OFF;
                end
            end
            ST_E_OFF:
            begin
                if (!off_hit)
                begin
                    state_next = ST_E_ADDR;
                end
                else if (emit_ok)
                begin
                    state_next = ST_REM;
                end
            end
            ST_REM:
            begin
                if (!rel_more)
                begin
                    state_next = ST_E_ADDR;
                end
            end
            ST_ADV: state_next = wrap ? ST_REL : ST_MUL;
            ST_PH: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ret_next = ret_reg;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        d_next = d_reg;
        r_next = r_reg;
        acc_next = acc_reg;
        pos_next = pos_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        ne_next = ne_reg;
        idx_next = idx_reg;
        si_next = si_reg;
        sk_next = sk_reg;
        bank_cnt_next = bank_cnt_reg;
        active_bank_next = active_bank_reg;
        snd_next = snd_reg;
        snd_cnt_next = snd_cnt_reg;
        playhead_next = playhead_reg;
        pending_next = pending_reg;
        seek_pending_next = seek_pending_reg;
        running_next = running_reg;
        hold_valid_next = hold_valid_reg;
        hold_next = hold_reg;
        ev_cnt_next = ev_cnt_reg;
        evt_valid_next = evt_valid_reg && evt_stall;
        evt_next = evt_reg;
        tbl_wr_en = 1'b0;
        tbl_wr_addr = AW'((active_bank_reg ? 0 : TABLE_ENTRIES))
                      + AW'(req_data.entry_index);
        tbl_wr_data.start = req_data.entry_start_beat;
        tbl_wr_data.length = req_data.entry_length_beat;
        tbl_wr_data.pitch = req_data.entry_pitch;
        emit_req = 1'b0;
        emit_kind = EV_OFF;
        emit_pitch = snd_reg[si_reg[SIW-1:0]];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ev_cnt_next = '0;
                    unique case (req_data.op)
                        OP_LOAD:
                        begin
                            tbl_wr_en = {1'b0, req_data.entry_index} < 5'(TABLE_ENTRIES);
                            if (req_data.load_last)
                            begin
                                bank_cnt_next[!active_bank_reg] =
                                    (load_c > 5'(TABLE_ENTRIES)) ? TCW'(TABLE_ENTRIES)
                                                                 : TCW'(load_c);
                                active_bank_next = !active_bank_reg;
                            end
                        end
                        OP_TICK:
                        begin
                            si_next = '0;
                            cnt_next = '0;
                            acc_next = '0;
                            phase_next = 1'b0;
                            if (!running_reg)
                            begin
                                ret_next = ST_FINISH;
                            end
                            else if (!degenerate && seek_pending_reg)
                            begin
                                seek_pending_next = 1'b0;
                                ret_next = ST_SEEK_SUB;
                            end
                        end
                        OP_PLAY:
                        begin
                            if ((playhead_reg < loop_start_reg)
                                || (playhead_reg >= loop_end_reg))
                            begin
                                playhead_next = loop_start_reg;
                                pending_next = loop_start_reg;
                            end
                            else
                            begin
                                pending_next = playhead_reg;
                            end
                            seek_pending_next = 1'b1;
                            running_next = 1'b1;
                        end
                        OP_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        OP_SEEK:
                        begin
                            playhead_next = req_data.seek_beat;
                            pending_next = req_data.seek_beat;
                            seek_pending_next = 1'b1;
                        end
                        default:
                        begin
                            ev_cnt_next = '0;
                        end
                    endcase
                end
            end
            ST_REL:
            begin
                if (rel_more)
                begin
                    emit_req = 1'b1;
                    if (emit_ok)
                    begin
                        si_next = si_reg + 1'b1;
                    end
                end
                else
                begin
                    snd_cnt_next = '0;
                    acc_next = '0;
                    cnt_next = '0;
                end
            end
            ST_SEEK_SUB:
            begin
                d_next = alu_y.sum[DIV_W-1:0];
            end
            ST_SEEK_ADD:
            begin
                d_next = alu_y.sum[DIV_W-1:0];
                r_next = '0;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                r_next = alu_y.carry ? alu_y.sum[REM_W-1:0] : rs;
                d_next = {d_reg[DIV_W-2:0], alu_y.carry};
                cnt_next = cnt_reg + 1'b1;
            end
            ST_CLAMP:
            begin
                pos_next = alu_y.carry ? d_reg[POS_W-1:0] : lenm1;
                acc_next = '0;
                cnt_next = '0;
                phase_next = 1'b0;
            end
            ST_MUL:
            begin
                acc_next = alu_y.sum[ACC_W-1:0];
                cnt_next = cnt_reg + 1'b1;
            end
            ST_SPAN_LO:
            begin
                lo_next = alu_y.sum;
            end
            ST_SPAN_HI:
            begin
                hi_next = alu_y.sum;
                idx_next = '0;
            end
            ST_E_NE:
            begin
                ne_next = alu_y.sum[DIV_W-1:0];
            end
            ST_E_ON:
            begin
                if (on_hit)
                begin
                    emit_req = 1'b1;
                    emit_kind = EV_ON;
                    emit_pitch = ent.pitch;
                    if (emit_ok && (snd_cnt_reg < SCW'(SOUNDING_SLOTS)))
                    begin
                        snd_next[snd_cnt_reg[SIW-1:0]] = ent.pitch;
                        snd_cnt_next = snd_cnt_reg + 1'b1;
                    end
                end
            end
            ST_E_OFF:
            begin
                si_next = '0;
                sk_next = '0;
                if (off_hit)
                begin
                    emit_req = 1'b1;
                    emit_kind = EV_OFF;
                    emit_pitch = ent.pitch;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_REM:
            begin
                // compact the list, dropping every copy of the released pitch
                if (rel_more)
                begin
                    if (snd_reg[si_reg[SIW-1:0]] != ent.pitch)
                    begin
                        snd_next[sk_reg[SIW-1:0]] = snd_reg[si_reg[SIW-1:0]];
                        sk_next = sk_reg + 1'b1;
                    end
                    si_next = si_reg + 1'b1;
                end
                else
                begin
                    snd_cnt_next = sk_reg;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_ADV:
            begin
                phase_next = 1'b1;
                acc_next = '0;
                cnt_next = '0;
                si_next = '0;
                ret_next = ST_MUL;
                pos_next = wrap ? '0 : np[POS_W-1:0];
            end
            ST_PH:
            begin
                playhead_next = (alu_y.sum[ALU_W-1:BEAT_W] != '0) ? BEAT_MAX
                                                                   : alu_y.sum[BEAT_W-1:0];
            end
            ST_FINISH:
            begin
                if (hold_valid_reg && out_free)
                begin
                    evt_valid_next = 1'b1;
                    evt_next = hold_reg;
                    evt_next.event_last = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase

        // one event held back so the final one can be marked
        if (emit_req && emit_ok && ev_room)
        begin
            if (hold_valid_reg)
            begin
                evt_valid_next = 1'b1;
                evt_next = hold_reg;
            end
            hold_valid_next = 1'b1;
            hold_next.event_kind = emit_kind;
            hold_next.event_pitch = emit_pitch;
            hold_next.event_last = 1'b0;
            ev_cnt_next = ev_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            cnt_reg <= '0;
            idx_reg <= '0;
            si_reg <= '0;
            sk_reg <= '0;
            bank_cnt_reg[0] <= '0;
            bank_cnt_reg[1] <= '0;
            active_bank_reg <= 1'b0;
            snd_cnt_reg <= '0;
            pos_reg <= '0;
            playhead_reg <= '0;
            pending_reg <= '0;
            seek_pending_reg <= 1'b0;
            running_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            ev_cnt_reg <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            si_reg <= si_next;
            sk_reg <= sk_next;
            bank_cnt_reg <= bank_cnt_next;
            active_bank_reg <= active_bank_next;
            snd_cnt_reg <= snd_cnt_next;
            pos_reg <= pos_next;
            playhead_reg <= playhead_next;
            pending_reg <= pending_next;
            seek_pending_reg <= seek_pending_next;
            running_reg <= running_next;
            hold_valid_reg <= hold_valid_next;
            ev_cnt_reg <= ev_cnt_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        r_reg <= r_next;
        acc_reg <= acc_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        ne_reg <= ne_next;
        snd_reg <= snd_next;
        hold_reg <= hold_next;
        evt_reg <= evt_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        snd_cnt_reg <= SCW'(SOUNDING_SLOTS))
        else $error("sounding count beyond slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        ev_cnt_reg <= MAX_EVENTS)
        else $error("event count beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held event left behind in idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_data.op != OP_TICK)) |=> (state_reg == ST_IDLE))
        else $error("non-tick request left the sequencer busy");

endmodule
`default_nettype wire
